// ===== sv/wifi_rx_frame_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the wifi receive frame classifier
// Clocked, reset-qualified implication checks shared by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef WIFI_RX_FRAME_CLASSIFIER_MACROS_SVH
`define WIFI_RX_FRAME_CLASSIFIER_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define WRFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define WRFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wrfc_pkg.sv =====
// ----------------------------------------------------------------------------
// wrfc_pkg
// Shared types and codes for the wifi receive frame classifier.
// ----------------------------------------------------------------------------
package wrfc_pkg;

    localparam int MAC_W = 48;

    // item kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_CLASSIFY = 2'd0,
        OP_WR_LOCAL = 2'd1,
        OP_WR_PEER  = 2'd2,
        OP_UNUSED   = 2'd3
    } t_opcode;

    // write request into the address tables
    typedef struct packed {
        logic             en;
        logic             sel_peer;
        logic [2:0]       idx;
        logic [MAC_W-1:0] mac;
    } t_tbl_wr;

    // scan request: source address and number of entries to walk per table
    typedef struct packed {
        logic             start;
        logic [MAC_W-1:0] sa;
        logic [3:0]       nl;
        logic [3:0]       np;
    } t_scan_req;

    typedef struct packed {
        logic done;
        logic hit_local;
        logic hit_peer;
    } t_scan_rsp;

endpackage

// ===== sv/wrfc_tables.sv =====
// ----------------------------------------------------------------------------
// wrfc_tables
// Local and peer source-address memories with a sequential lookup walk.
// ----------------------------------------------------------------------------
`include "wifi_rx_frame_classifier_macros.svh"

module wrfc_tables #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wrfc_pkg::t_tbl_wr   i_wr,
    input  wrfc_pkg::t_scan_req i_req,
    output wrfc_pkg::t_scan_rsp o_rsp
);
    import wrfc_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic {
        T_IDLE,
        T_SCAN
    } t_tstate;

    logic [MAC_W-1:0] local_mem [TABLE_DEPTH];
    logic [MAC_W-1:0] peer_mem  [TABLE_DEPTH];

    t_tstate          r_state;
    logic [3:0]       r_cnt;
    logic [3:0]       r_span;
    logic [3:0]       r_nl;
    logic [3:0]       r_np;
    logic [MAC_W-1:0] r_sa;
    logic             r_lv;
    logic             r_pv;
    logic             r_hit_l;
    logic             r_hit_p;
    logic             r_done;
    logic [MAC_W-1:0] r_loc_q;
    logic [MAC_W-1:0] r_peer_q;

    logic             w_wr_ok;
    logic [AW-1:0]    w_wr_addr;
    logic [AW-1:0]    w_rd_addr;
    logic             w_issue;
    logic [MAC_W-1:0] w_peer_exp;

    assign w_wr_ok   = int'(i_wr.idx) < TABLE_DEPTH;
    assign w_wr_addr = AW'(i_wr.idx);
    assign w_rd_addr = AW'(r_cnt);
    assign w_issue   = (r_state == T_SCAN) && (r_cnt != r_span);

    // peer entries are stored half-swapped, except when only the lower half is nonzero
    always_comb begin
        if (r_peer_q[47:24] == 24'd0 && r_peer_q[23:0] != 24'd0) begin
            w_peer_exp = r_peer_q;
        end else begin
            w_peer_exp = {r_peer_q[23:0], r_peer_q[47:24]};
        end
    end

    // memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (i_wr.en && w_wr_ok) begin
            if (i_wr.sel_peer) begin
                peer_mem[w_wr_addr] <= i_wr.mac;
            end else begin
                local_mem[w_wr_addr] <= i_wr.mac;
            end
        end
        if (w_issue) begin
            r_loc_q  <= local_mem[w_rd_addr];
            r_peer_q <= peer_mem[w_rd_addr];
        end
    end

    // walk: issue read n, compare read n-1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_cnt   <= '0;
            r_span  <= '0;
            r_nl    <= '0;
            r_np    <= '0;
            r_sa    <= '0;
            r_lv    <= 1'b0;
            r_pv    <= 1'b0;
            r_hit_l <= 1'b0;
            r_hit_p <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_lv   <= 1'b0;
            r_pv   <= 1'b0;
            unique case (r_state)
                T_IDLE: begin
                    if (i_req.start) begin
                        r_sa    <= i_req.sa;
                        r_nl    <= i_req.nl;
                        r_np    <= i_req.np;
                        r_span  <= (i_req.nl > i_req.np) ? i_req.nl : i_req.np;
                        r_cnt   <= '0;
                        r_hit_l <= 1'b0;
                        r_hit_p <= 1'b0;
                        r_state <= T_SCAN;
                    end
                end
                T_SCAN: begin
                    if (r_lv && r_loc_q == r_sa) begin
                        r_hit_l <= 1'b1;
                    end
                    if (r_pv && w_peer_exp == r_sa) begin
                        r_hit_p <= 1'b1;
                    end
                    if (w_issue) begin
                        r_lv  <= r_cnt < r_nl;
                        r_pv  <= r_cnt < r_np;
                        r_cnt <= r_cnt + 4'd1;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.hit_local = r_hit_l;
    assign o_rsp.hit_peer  = r_hit_p;

    `WRFC_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_req.start, r_state == T_IDLE, "scan start while busy")
    `WRFC_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "done held longer than one cycle")
    `WRFC_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_state == T_SCAN, r_cnt <= r_span, "walk ran past span")

endmodule

// ===== sv/wifi_rx_frame_classifier.sv =====
// ----------------------------------------------------------------------------
// wifi_rx_frame_classifier
// Receive filter for 802.11 data frame headers with address-table lookup.
// ----------------------------------------------------------------------------
// One result item per input item. Write items (local or peer table slot) and
// the unused kind return an all-zero result through S_OUT and the output
// register. A classify item waits in S_WAIT for the table walk and then goes
// through S_OUT and the output register. Tunnel mode walks nothing; standalone
// mode walks both tables in step, max(local_count, peer_count) entries deep
// (clamped to TABLE_DEPTH), one entry a cycle through single read ports. The
// next item is taken from the cycle after the result is loaded into the output
// register, and the output register lets the block take an item while the
// previous result waits; a new result is only loaded once the old one is gone.
// Table entries have no reset value: only written entries within the counts
// may be looked up. Registers sit on the APB port at byte addresses 0 (mode),
// 8 (bssid), 16 (station_mac), 24 (local_count) and 32 (peer_count), 64-bit
// data; write them only while the block is idle.
// ----------------------------------------------------------------------------
`include "wifi_rx_frame_classifier_macros.svh"

module wifi_rx_frame_classifier #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // fc[7:0], len[20:8], dest[68:21], src[116:69], bss[164:117],
    // idx[167:165], mac[215:168]
    input  logic [215:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // class[1:0], offset[6:2], bssid_match[7], heard[8], zero[15:9]
    output logic [15:0]  m_tdata
);
    import wrfc_pkg::*;

    // register indexes (paddr[5:3])
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_BSSID   = 3'd1;
    localparam logic [2:0] REG_STA_MAC = 3'd2;
    localparam logic [2:0] REG_LOC_CNT = 3'd3;
    localparam logic [2:0] REG_PEER_CNT = 3'd4;

    // frame control fields
    localparam logic [7:0] FC_TYPE_MASK = 8'h0C;
    localparam logic [7:0] FC_TYPE_DATA = 8'h08;
    localparam logic [7:0] FC_SUB_MASK  = 8'hF0;
    localparam logic [7:0] FC_SUB_PLAIN = 8'h00;
    localparam logic [7:0] FC_SUB_QOS   = 8'h80;
    localparam logic [4:0] HDR_PLAIN    = 5'd24;
    localparam logic [4:0] HDR_QOS      = 5'd26;
    localparam logic [12:0] ADDR3_END   = 13'd22;
    localparam logic [MAC_W-1:0] MAC_BCAST = '1;

    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_SELF  = 2'd1;
    localparam logic [1:0] CLS_MATCH = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_OUT
    } t_state;

    // configuration
    logic             r_mode;
    logic [MAC_W-1:0] r_bssid;
    logic [MAC_W-1:0] r_sta_mac;
    logic [3:0]       r_loc_cnt;
    logic [3:0]       r_peer_cnt;

    // per-item control
    t_state           r_state;
    logic [4:0]       r_hdr;
    logic             r_bss_ok;
    logic             r_da_bc;
    logic             r_sa_self;
    logic             r_hit_l;
    logic             r_hit_p;

    // output register
    logic             r_ovld;
    logic [1:0]       r_cls;
    logic [4:0]       r_off;
    logic             r_bm;
    logic             r_heard;

    // unpacked input fields
    t_opcode          w_op;
    logic [7:0]       w_fc;
    logic [12:0]      w_len;
    logic [MAC_W-1:0] w_da;
    logic [MAC_W-1:0] w_sa;
    logic [MAC_W-1:0] w_a3;
    logic [2:0]       w_idx;
    logic [MAC_W-1:0] w_mac;

    logic             w_cfg_wr;
    logic [2:0]       w_reg;
    logic             w_in_acc;
    logic             w_out_free;
    logic [3:0]       w_nl_eff;
    logic [3:0]       w_np_eff;
    logic [4:0]       w_hdr;
    logic             w_gate;
    logic [1:0]       w_cls;
    logic             w_heard;

    t_tbl_wr          w_tbl_wr;
    t_scan_req        w_req;
    t_scan_rsp        w_rsp;

    assign w_op  = t_opcode'(s_tuser);
    assign w_fc  = s_tdata[7:0];
    assign w_len = s_tdata[20:8];
    assign w_da  = s_tdata[68:21];
    assign w_sa  = s_tdata[116:69];
    assign w_a3  = s_tdata[164:117];
    assign w_idx = s_tdata[167:165];
    assign w_mac = s_tdata[215:168];

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_reg    = paddr[5:3];
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (w_reg)
            REG_MODE:     prdata = {63'd0, r_mode};
            REG_BSSID:    prdata = {16'd0, r_bssid};
            REG_STA_MAC:  prdata = {16'd0, r_sta_mac};
            REG_LOC_CNT:  prdata = {60'd0, r_loc_cnt};
            REG_PEER_CNT: prdata = {60'd0, r_peer_cnt};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_bssid    <= '0;
            r_sta_mac  <= '0;
            r_loc_cnt  <= '0;
            r_peer_cnt <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_MODE:     r_mode     <= pwdata[0];
                REG_BSSID:    r_bssid    <= pwdata[47:0];
                REG_STA_MAC:  r_sta_mac  <= pwdata[47:0];
                REG_LOC_CNT:  r_loc_cnt  <= pwdata[3:0];
                REG_PEER_CNT: r_peer_cnt <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // counts above the table depth act as the depth
    assign w_nl_eff = (int'(r_loc_cnt) > TABLE_DEPTH) ? 4'(TABLE_DEPTH) : r_loc_cnt;
    assign w_np_eff = (int'(r_peer_cnt) > TABLE_DEPTH) ? 4'(TABLE_DEPTH) : r_peer_cnt;

    // header length: plain data 24, QoS data 26, anything else 0
    always_comb begin
        w_hdr = 5'd0;
        if (w_len >= 13'(HDR_PLAIN) && (w_fc & FC_TYPE_MASK) == FC_TYPE_DATA) begin
            if ((w_fc & FC_SUB_MASK) == FC_SUB_QOS) begin
                w_hdr = (w_len >= 13'(HDR_QOS)) ? HDR_QOS : 5'd0;
            end else if ((w_fc & FC_SUB_MASK) == FC_SUB_PLAIN) begin
                w_hdr = HDR_PLAIN;
            end
        end
    end

    // ---------------- handshake and table access ----------------
    // a waiting result does not hold the input; it only holds the next load
    assign w_out_free = !r_ovld || m_tready;
    assign s_tready   = (r_state == S_IDLE);
    assign w_in_acc   = s_tvalid && s_tready;

    assign w_tbl_wr.en       = w_in_acc && (w_op == OP_WR_LOCAL || w_op == OP_WR_PEER);
    assign w_tbl_wr.sel_peer = (w_op == OP_WR_PEER);
    assign w_tbl_wr.idx      = w_idx;
    assign w_tbl_wr.mac      = w_mac;

    // tunnel mode needs no walk
    assign w_req.start = w_in_acc && (w_op == OP_CLASSIFY);
    assign w_req.sa    = w_sa;
    assign w_req.nl    = r_mode ? w_nl_eff : 4'd0;
    assign w_req.np    = r_mode ? w_np_eff : 4'd0;

    wrfc_tables #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_tables (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_tbl_wr),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // ---------------- classification ----------------
    assign w_gate = (r_hdr != 5'd0) && r_da_bc && r_bss_ok;

    always_comb begin
        w_cls   = CLS_NONE;
        w_heard = 1'b0;
        if (!r_mode) begin
            w_heard = r_bss_ok;
            if (w_gate) begin
                if (r_sa_self) begin
                    w_cls = CLS_SELF;
                end else if (w_np_eff != 4'd0) begin
                    w_cls = CLS_MATCH;
                end
            end
        end else begin
            w_heard = r_bss_ok && (r_hit_l || r_hit_p);
            if (w_gate) begin
                if (r_hit_l) begin
                    w_cls = CLS_SELF;
                end else if (r_hit_p) begin
                    w_cls = CLS_MATCH;
                end
            end
        end
    end

    // ---------------- sequencer and output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovld    <= 1'b0;
            r_hdr     <= '0;
            r_bss_ok  <= 1'b0;
            r_da_bc   <= 1'b0;
            r_sa_self <= 1'b0;
            r_hit_l   <= 1'b0;
            r_hit_p   <= 1'b0;
            r_cls     <= '0;
            r_off     <= '0;
            r_bm      <= 1'b0;
            r_heard   <= 1'b0;
        end else begin
            if (m_tready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_op == OP_CLASSIFY) begin
                            r_hdr     <= w_hdr;
                            r_bss_ok  <= (w_len >= ADDR3_END) && (w_a3 == r_bssid);
                            r_da_bc   <= (w_da == MAC_BCAST);
                            r_sa_self <= (w_sa == r_sta_mac);
                            r_state   <= S_WAIT;
                        end else begin
                            // table writes and the unused kind give an empty result:
                            // no header and no BSSID match clear every field
                            r_hdr    <= 5'd0;
                            r_bss_ok <= 1'b0;
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_WAIT: begin
                    if (w_rsp.done) begin
                        r_hit_l <= w_rsp.hit_local;
                        r_hit_p <= w_rsp.hit_peer;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovld  <= 1'b1;
                        r_cls   <= w_cls;
                        r_off   <= (w_cls == CLS_MATCH) ? r_hdr : 5'd0;
                        r_bm    <= r_bss_ok;
                        r_heard <= w_heard;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_ovld;
    assign m_tdata  = {7'd0, r_heard, r_bm, r_off, r_cls};

    `WRFC_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, w_rsp.done, r_state == S_WAIT, "done outside wait")
    `WRFC_ASSERT_NXT(a_classify_waits, i_clk, i_rst_n, w_req.start, r_state == S_WAIT, "no lookup")
    `WRFC_ASSERT_IMP(a_match_offset, i_clk, i_rst_n, r_ovld && r_cls == CLS_MATCH, r_off == HDR_PLAIN || r_off == HDR_QOS, "bad offset")
    `WRFC_ASSERT_IMP(a_heard_bssid, i_clk, i_rst_n, r_ovld && r_heard, r_bm, "heard without BSSID match")

endmodule
